### design/caldc_pkg.sv
// Package for the calendar date counter: item types, controller/datapath
// command and status structs, calendar constants and month-length helpers.
// No dependencies.
package caldc_pkg;

   localparam int unsigned DAY_BITS   = 5;
   localparam int unsigned MONTH_BITS = 4;
   localparam int unsigned SYEAR_BITS = 12;
   localparam int unsigned OYEAR_BITS = 16;
   localparam int unsigned CNT_BITS   = 16;
   localparam int unsigned R400_BITS  = 9;

   localparam logic [SYEAR_BITS-1:0] YEAR_MIN     = 12'd1000;
   localparam logic [SYEAR_BITS-1:0] YEAR_MAX     = 12'd3007;
   localparam logic [SYEAR_BITS-1:0] YEAR_DEFAULT = 12'd1994;
   localparam logic [DAY_BITS-1:0]   LEAP_FEB_DAYS = 5'd29;
   localparam logic [MONTH_BITS-1:0] MONTH_FEB    = 4'd2;
   localparam logic [MONTH_BITS-1:0] MONTH_DEC    = 4'd12;
   localparam logic [DAY_BITS-1:0]   DAY_LAST_DEC = 5'd31;
   localparam logic [R400_BITS-1:0]  R400_LAST    = 9'd399;

   localparam logic [DAY_BITS-1:0] MONTH_LEN [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
   };

   typedef struct packed {
      logic                  op;
      logic [5:0]            set_day;
      logic [MONTH_BITS-1:0] set_month;
      logic [SYEAR_BITS-1:0] set_year;
      logic [CNT_BITS-1:0]   advance_days;
   } req_type;

   typedef struct packed {
      logic [DAY_BITS-1:0]   cur_day;
      logic [MONTH_BITS-1:0] cur_month;
      logic [OYEAR_BITS-1:0] cur_year;
      logic                  month_end;
   } rsp_type;

   typedef struct packed {
      logic load_set;
      logic load_count;
      logic step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic out_free;
   } status_type;

   // Leap test from year mod 400: divisible by 4 and not a century, or a multiple of 400.
   function automatic logic is_leap(input logic [R400_BITS-1:0] r400);
      return (r400[1:0] == 2'd0) &&
             !(r400 == 9'd100 || r400 == 9'd200 || r400 == 9'd300);
   endfunction

   function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                     input logic leap);
      if (m == MONTH_FEB && leap)
         return LEAP_FEB_DAYS;
      return MONTH_LEN[m];
   endfunction

   // Year mod 400 for a validated year below 3200.
   function automatic logic [R400_BITS-1:0] year_mod400(input logic [SYEAR_BITS-1:0] y);
      logic [SYEAR_BITS-1:0] base;
      if (y >= 12'd2800)
         base = 12'd2800;
      else if (y >= 12'd2400)
         base = 12'd2400;
      else if (y >= 12'd2000)
         base = 12'd2000;
      else if (y >= 12'd1600)
         base = 12'd1600;
      else if (y >= 12'd1200)
         base = 12'd1200;
      else if (y >= 12'd800)
         base = 12'd800;
      else if (y >= 12'd400)
         base = 12'd400;
      else
         base = 12'd0;
      return R400_BITS'(y - base);
   endfunction

endpackage

### design/caldc_stream_if.sv
// Valid/ready item channel carrying one payload struct.
// Payload type is supplied by the instantiating level (see caldc_pkg).
interface caldc_stream_if #(parameter type payload_type = logic [0:0]);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/calendar_date_counter.sv
// Gregorian day counter. An item either loads a date (each field validated)
// or advances the date by advance_days; every item returns one result.
// A set item loads the date on acceptance; an advance counts down n days while
// the date stepper moves one day per cycle. The result is registered once the
// count is zero and the result register is free. One item is in work at a time;
// the next is accepted as the result shows, even while it awaits rsp_chan.ready.
// Years wrap at YEAR_BITS; cur_year shows the low 16 bits. Depends on
// caldc_pkg, caldc_stream_if, caldc_ctrl and caldc_dp.
module calendar_date_counter #(
   parameter int unsigned YEAR_BITS = 16
) (
   input logic             clock,
   input logic             reset,
   caldc_stream_if.sink    req_chan,
   caldc_stream_if.source  rsp_chan
);
   import caldc_pkg::*;

   cmd_type    cmd;
   status_type status;
   req_type    req_data;
   rsp_type    rsp_data;
   logic       req_ready;
   logic       rsp_valid;

   assign req_data         = req_chan.payload;
   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_data;

   caldc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_data.op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   caldc_dp #(
      .YEAR_BITS (YEAR_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule

### design/caldc_ctrl.sv
// Controller for the calendar date counter: idle/run sequencing.
// Depends on caldc_pkg; drives datapath commands from its status.
module caldc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_op,
   output logic                    req_ready,
   input  caldc_pkg::status_type   status,
   output caldc_pkg::cmd_type      cmd
);
   import caldc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.load_set   = accept && !req_op;
      cmd.load_count = accept && req_op;
      cmd.step       = (state_ff == ST_RUN) && !status.cnt_zero;
      cmd.publish    = (state_ff == ST_RUN) && status.cnt_zero && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept)
               state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.cnt_zero && status.out_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_set, cmd.load_count, cmd.step, cmd.publish}))
      else $error("more than one datapath command");
   a_publish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> req_ready)
      else $error("not idle after result");
   a_accept_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("accepted item did not start work");
endmodule

### design/caldc_dp.sv
// Datapath for the calendar date counter: date registers, day stepper,
// set validation, day countdown and result register. Depends on caldc_pkg.
module caldc_dp #(
   parameter int unsigned YEAR_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  caldc_pkg::cmd_type      cmd,
   output caldc_pkg::status_type   status,
   input  caldc_pkg::req_type      req_data,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output caldc_pkg::rsp_type      rsp_data
);
   import caldc_pkg::*;

   localparam logic [YEAR_BITS-1:0] YEAR_TOP = '1;

   logic [DAY_BITS-1:0]   day_ff, day_in;
   logic [MONTH_BITS-1:0] month_ff, month_in;
   logic [YEAR_BITS-1:0]  year_ff, year_in;
   logic [R400_BITS-1:0]  r400_ff, r400_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [MONTH_BITS-1:0] set_m;
   logic [SYEAR_BITS-1:0] set_y;
   logic [R400_BITS-1:0]  set_r400;
   logic [DAY_BITS-1:0]   set_len;
   logic [DAY_BITS-1:0]   set_d;
   logic [DAY_BITS-1:0]   cur_len;
   logic                  cur_month_end;
   logic [YEAR_BITS+OYEAR_BITS-1:0] year_ext;

   // set validation
   always_comb begin
      set_m    = (req_data.set_month >= 4'd1 && req_data.set_month <= MONTH_DEC) ?
                 req_data.set_month : 4'd1;
      set_y    = (req_data.set_year >= YEAR_MIN && req_data.set_year <= YEAR_MAX) ?
                 req_data.set_year : YEAR_DEFAULT;
      set_r400 = year_mod400(set_y);
      set_len  = month_len(set_m, is_leap(set_r400));
      set_d    = (req_data.set_day != 6'd0 && req_data.set_day <= 6'(set_len)) ?
                 req_data.set_day[DAY_BITS-1:0] : 5'd1;
   end

   assign cur_len       = month_len(month_ff, is_leap(r400_ff));
   assign cur_month_end = (day_ff == cur_len);

   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      r400_in  = r400_ff;
      cnt_in   = cnt_ff;
      if (cmd.load_set) begin
         day_in   = set_d;
         month_in = set_m;
         year_in  = YEAR_BITS'(set_y);
         r400_in  = set_r400;
         cnt_in   = '0;
      end else if (cmd.load_count) begin
         cnt_in = req_data.advance_days;
      end else if (cmd.step) begin
         cnt_in = cnt_ff - 1'b1;
         if (month_ff == MONTH_DEC && day_ff == DAY_LAST_DEC) begin
            year_in  = year_ff + 1'b1;
            day_in   = 5'd1;
            month_in = 4'd1;
            // year 0 after wrap is a multiple of 400
            if (year_ff == YEAR_TOP || r400_ff == R400_LAST)
               r400_in = '0;
            else
               r400_in = r400_ff + 1'b1;
         end else if (cur_month_end) begin
            month_in = month_ff + 1'b1;
            day_in   = 5'd1;
         end else begin
            day_in = day_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff   <= 5'd1;
         month_ff <= 4'd1;
         year_ff  <= YEAR_BITS'(YEAR_DEFAULT);
         r400_ff  <= year_mod400(YEAR_DEFAULT);
      end else begin
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
         r400_ff  <= r400_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

   assign year_ext = {{OYEAR_BITS{1'b0}}, year_ff};

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.publish)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_data_ff.cur_day   <= day_ff;
         rsp_data_ff.cur_month <= month_ff;
         rsp_data_ff.cur_year  <= year_ext[OYEAR_BITS-1:0];
         rsp_data_ff.month_end <= cur_month_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.cnt_zero = (cnt_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      month_ff >= 4'd1 && month_ff <= MONTH_DEC)
      else $error("month register out of range");
   a_day_range: assert property (@(posedge clock) disable iff (reset)
      day_ff >= 5'd1 && day_ff <= cur_len)
      else $error("day register beyond month length");
   a_publish_data: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff && rsp_data_ff.cur_day == $past(day_ff)
                      && rsp_data_ff.month_end == $past(cur_month_end))
      else $error("result register not loaded from date");
endmodule

### test/tb.sv
// Testbench for calendar_date_counter: directed and random set/advance items, predicted
// by a day-stepping date tracker and checked field by field on every result.
// Depends on caldc_pkg, caldc_stream_if and the calendar_date_counter RTL.
module tb;
   import caldc_pkg::*;

   typedef enum logic {OP_SET = 1'b0, OP_ADVANCE = 1'b1} date_op_type;

   class calendar_tracker_type;
      logic [DAY_BITS-1:0]   day;
      logic [MONTH_BITS-1:0] month;
      logic [15:0]           year;
      rsp_type               expected_dates[$];
      int unsigned           errors;

      function new();
         day = 5'd1;
         month = 4'd1;
         year = 16'(YEAR_DEFAULT);
         errors = 0;
      endfunction

      function bit leap(logic [15:0] y);
         int unsigned v;
         v = 32'(y);
         return (v % 400 == 0) || ((v % 4 == 0) && (v % 100 != 0));
      endfunction

      function logic [DAY_BITS-1:0] month_days(logic [MONTH_BITS-1:0] m, logic [15:0] y);
         case (m)
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            MONTH_FEB:               return leap(y) ? LEAP_FEB_DAYS : 5'd28;
            default:                 return 5'd31;
         endcase
      endfunction

      function void advance_one_day();
         if (month == MONTH_DEC && day == DAY_LAST_DEC) begin
            year = year + 16'd1;
            month = 4'd1;
            day = 5'd1;
         end else if (day == month_days(month, year)) begin
            month = month + 4'd1;
            day = 5'd1;
         end else begin
            day = day + 5'd1;
         end
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         logic [DAY_BITS-1:0] len;
         if (r.op == OP_SET) begin
            month = (r.set_month >= 4'd1 && r.set_month <= 4'd12) ? r.set_month : 4'd1;
            year = (r.set_year >= YEAR_MIN && r.set_year <= YEAR_MAX) ?
                   16'(r.set_year) : 16'(YEAR_DEFAULT);
            len = month_days(month, year);
            day = (r.set_day >= 6'd1 && r.set_day <= 6'(len)) ? r.set_day[4:0] : 5'd1;
         end else begin
            for (int unsigned i = 0; i < r.advance_days; i++)
               advance_one_day();
         end
         e.cur_day = day;
         e.cur_month = month;
         e.cur_year = year;
         e.month_end = (day == month_days(month, year));
         expected_dates.push_back(e);
      endfunction

      function void check_date(rsp_type got);
         rsp_type e;
         if (expected_dates.size() == 0) begin
            $error("result with no item pending: %0d/%0d/%0d",
                   got.cur_day, got.cur_month, got.cur_year);
            errors++;
            return;
         end
         e = expected_dates.pop_front();
         if (got.cur_day !== e.cur_day) begin
            $error("cur_day: expected %0d, got %0d", e.cur_day, got.cur_day);
            errors++;
         end
         if (got.cur_month !== e.cur_month) begin
            $error("cur_month: expected %0d, got %0d", e.cur_month, got.cur_month);
            errors++;
         end
         if (got.cur_year !== e.cur_year) begin
            $error("cur_year: expected %0d, got %0d", e.cur_year, got.cur_year);
            errors++;
         end
         if (got.month_end !== e.month_end) begin
            $error("month_end: expected %0d, got %0d", e.month_end, got.month_end);
            errors++;
         end
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   caldc_stream_if #(.payload_type(req_type)) req_if ();
   caldc_stream_if #(.payload_type(rsp_type)) rsp_if ();

   calendar_date_counter uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   calendar_tracker_type tracker = new();
   int unsigned          burst_left = 0;

   always #10 clock = ~clock;

   function automatic req_type set_item(int unsigned d, int unsigned m, int unsigned y);
      req_type r;
      r.op = OP_SET;
      r.set_day = 6'(d);
      r.set_month = 4'(m);
      r.set_year = 12'(y);
      r.advance_days = 16'($urandom());
      return r;
   endfunction

   function automatic req_type advance_item(int unsigned n);
      req_type r;
      r.op = OP_ADVANCE;
      r.set_day = 6'($urandom());
      r.set_month = 4'($urandom());
      r.set_year = 12'($urandom());
      r.advance_days = 16'(n);
      return r;
   endfunction

   task automatic send_item(input req_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      tracker.note_request(r);
      burst_left--;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // result side: check on accept, then pick next ready from the current stall mode
   initial begin
      int unsigned mode, mode_left, cyc;
      rsp_if.ready = 1'b0;
      mode = 0;
      mode_left = 0;
      cyc = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            tracker.check_date(rsp_if.payload);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         cyc++;
         case (mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= (cyc % 4 == 0);
            default: rsp_if.ready <= (mode_left < 5);
         endcase
      end
   end

   initial begin
      int unsigned sel, d, m, y;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(advance_item(0));
      send_item(set_item(31, 12, 1999));
      send_item(advance_item(1));
      send_item(set_item(28, 2, 2000));
      send_item(advance_item(1));
      send_item(advance_item(1));
      send_item(set_item(29, 2, 1900));
      send_item(set_item(28, 2, 1900));
      send_item(advance_item(1));
      send_item(set_item(29, 2, 2004));
      send_item(set_item(0, 0, 999));
      send_item(set_item(63, 15, 4095));
      send_item(set_item(31, 4, 1000));
      send_item(set_item(30, 13, 3007));
      send_item(set_item(15, 6, 3008));
      send_item(set_item(0, 0, 0));
      send_item(set_item(30, 9, 2023));
      send_item(advance_item(1));
      send_item(set_item(31, 12, 3007));
      send_item(advance_item(65535));
      send_item(advance_item(0));
      send_item(set_item(31, 1, 1996));
      send_item(advance_item(29));

      for (int i = 0; i < 750; i++) begin
         if (i == 375)
            wait_drained();
         sel = $urandom_range(0, 99);
         if (i == 250 || i == 500) begin
            send_item(advance_item($urandom_range(0, 65535)));
         end else if (sel < 30) begin
            y = ($urandom_range(0, 9) < 7) ? $urandom_range(1000, 3007) : $urandom_range(0, 4095);
            m = ($urandom_range(0, 19) < 17) ? $urandom_range(1, 12) : $urandom_range(0, 15);
            d = $urandom_range(0, 1) ? $urandom_range(27, 31) : $urandom_range(0, 63);
            send_item(set_item(d, m, y));
         end else if (sel < 85) begin
            send_item(advance_item($urandom_range(0, 40)));
         end else if (sel < 97) begin
            send_item(advance_item($urandom_range(0, 500)));
         end else begin
            send_item(advance_item($urandom_range(300, 2000)));
         end
      end

      req_if.valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.errors == 0)
         $display("** calendar_date_counter: PASSED **");
      else
         $display("** calendar_date_counter: FAILED **");
      $finish;
   end

   initial begin
      #80_000_000;
      $display("** calendar_date_counter: FAILED **");
      $finish;
   end
endmodule
